@@ hdl/tti_pkg.sv @@
// Shared types, constants and helpers for the trajectory table interpolator.
`timescale 1ns / 1ps
`default_nettype none

package tti_pkg;

    // Default sizing
    localparam int MAX_SAMPLES_DEF   = 1024;
    localparam int FRACTION_BITS_DEF = 16;

    // Seven interpolated values: pos x/y/z, vel x/y/z, Mach
    localparam int          NUM_LANES = 7;
    localparam logic [2:0]  LANE_LAST = 3'd6;
    localparam logic [2:0]  LANE_MACH = 3'd6;

    // Action codes (any other code runs a query)
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;

    // Status codes
    localparam logic [2:0] ST_INTERP  = 3'd0;
    localparam logic [2:0] ST_BEFORE  = 3'd1;
    localparam logic [2:0] ST_AFTER   = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_WRITTEN = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SRCH,
        S_RDLO,
        S_DIV,
        S_MUL,
        S_ADD,
        S_DONE
    } state_t;

    // One stored sample, one memory row
    typedef struct packed {
        logic [31:0]       t;
        logic [2:0][31:0]  pos;
        logic [2:0][31:0]  vel;
        logic [15:0]       mach;
    } sample_row_t;

    localparam int ROW_W = $bits(sample_row_t);

    // Value of one lane of a row, Mach zero-extended
    function automatic logic [31:0] lane_val(sample_row_t r, logic [2:0] k);
        logic [31:0] v;
        case (k)
            3'd0:    v = r.pos[0];
            3'd1:    v = r.pos[1];
            3'd2:    v = r.pos[2];
            3'd3:    v = r.vel[0];
            3'd4:    v = r.vel[1];
            3'd5:    v = r.vel[2];
            default: v = {16'h0000, r.mach};
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hdl/tti_in_if.sv @@
// Command channel: action and sample/query payload with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface tti_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [31:0]        sample_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [15:0]        mach_number;
    logic [31:0]        query_time;

    modport source (
        output valid, action, sample_time, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z, mach_number, query_time,
        input  ready
    );
    modport sink (
        input  valid, action, sample_time, pos_x, pos_y, pos_z,
               vel_x, vel_y, vel_z, mach_number, query_time,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/tti_out_if.sv @@
// Result channel: status and interpolated values with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface tti_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic [15:0]        out_mach;

    modport source (
        output valid, status, out_pos_x, out_pos_y, out_pos_z,
               out_vel_x, out_vel_y, out_vel_z, out_mach,
        input  ready
    );
    modport sink (
        input  valid, status, out_pos_x, out_pos_y, out_pos_z,
               out_vel_x, out_vel_y, out_vel_z, out_mach,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/tti_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module tti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/tti_div.sv @@
// Restoring divider: fraction (num << FRACTION_BITS) / den, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tti_div #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [31:0]              num,
    input  wire logic [31:0]              den,
    output logic                          busy,
    output logic [FRACTION_BITS-1:0]      quot
);

    localparam int CW = $clog2(FRACTION_BITS + 1);

    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [31:0]              rem_reg, rem_next;
    logic [31:0]              den_reg, den_next;
    logic [FRACTION_BITS-1:0] quot_reg, quot_next;
    logic [32:0]              shifted;
    logic [32:0]              trial;
    logic                     fits;

    // One shift-compare-subtract step; num < den keeps rem in 32 bits
    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        trial     = shifted - {1'b0, den_reg};
        fits      = shifted >= {1'b0, den_reg};
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            cnt_next  = CW'(FRACTION_BITS);
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CW'(1);
            rem_next  = fits ? trial[31:0] : shifted[31:0];
            quot_next = {quot_reg[FRACTION_BITS-2:0], fits};
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign busy = cnt_reg != '0;
    assign quot = quot_reg;

endmodule

`default_nettype wire

@@ hdl/tti_blend.sv @@
// Shared blend unit: a + floor((b - a) * f / 2^FRACTION_BITS), multiply then add.
`timescale 1ns / 1ps
`default_nettype none

module tti_blend #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     mul_en,
    input  wire logic [31:0]              a,
    input  wire logic [31:0]              b,
    input  wire logic                     sgn,
    input  wire logic [FRACTION_BITS-1:0] f,
    output logic [31:0]                   result
);

    localparam int PW = 33 + FRACTION_BITS + 1;

    logic signed [32:0]          a_ext;
    logic signed [32:0]          b_ext;
    logic signed [32:0]          diff;
    logic signed [FRACTION_BITS:0] f_ext;
    logic signed [PW-1:0]        prod_reg;
    logic signed [PW-1:0]        prod_shift;

    // Difference fits 33 bits for both signed and unsigned lanes
    always_comb
    begin
        a_ext = $signed({sgn & a[31], a});
        b_ext = $signed({sgn & b[31], b});
        diff  = b_ext - a_ext;
        f_ext = $signed({1'b0, f});
    end

    // Product register
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= diff * f_ext;
        end
    end

    // Arithmetic shift floors toward minus infinity
    always_comb
    begin
        prod_shift = prod_reg >>> FRACTION_BITS;
        result     = a + prod_shift[31:0];
    end

endmodule

`default_nettype wire

@@ hdl/trajectory_table_interpolator_unit.sv @@
// Top level of the trajectory table interpolator: sequencer, sample RAM and arithmetic units.
`timescale 1ns / 1ps
`default_nettype none

// Holds up to MAX_SAMPLES trajectory samples (time, position, velocity, Mach)
// in one RAM row each and answers one command at a time. Clear and append
// finish without a RAM read. A query that clamps to the first or last
// sample ends once those rows are read; an interpolating query runs longer,
// its time set by the single RAM read port used once per binary-search
// step, the bit-serial divider and the one shared multiplier that blends
// the seven values in turn. The result sits in an output register, so it
// may wait while the block already goes back to ready once the register is
// free. There is no clearing pass after reset.
module trajectory_table_interpolator_unit #(
    parameter int MAX_SAMPLES   = tti_pkg::MAX_SAMPLES_DEF,
    parameter int FRACTION_BITS = tti_pkg::FRACTION_BITS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    tti_in_if.sink    cmd,
    tti_out_if.source res
);

    import tti_pkg::*;

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [31:0]                qt_reg, qt_next;
    logic [AW-1:0]              lo_reg, lo_next;
    logic [AW-1:0]              hi_reg, hi_next;
    logic [AW-1:0]              mid_reg, mid_next;
    sample_row_t                lo_row_reg, lo_row_next;
    sample_row_t                hi_row_reg, hi_row_next;
    logic [2:0]                 lane_reg, lane_next;
    logic [2:0]                 rstat_reg, rstat_next;
    logic [NUM_LANES-1:0][31:0] rval_reg, rval_next;
    logic                       out_valid_reg, out_valid_next;
    logic [2:0]                 out_status_reg;
    logic [NUM_LANES-1:0][31:0] out_val_reg;

    logic                       accept;
    logic                       full;
    logic                       out_load;
    logic [AW-1:0]              n_m1;
    logic [AW-1:0]              cand_lo, cand_hi, cand_mid, cand_gap;
    logic [AW:0]                mid_sum;
    logic                       search_more;

    logic                       ram_we;
    logic [AW-1:0]              ram_raddr;
    sample_row_t                ram_wdata;
    sample_row_t                ram_rdata;

    logic                       div_start;
    logic [31:0]                div_num, div_den;
    logic                       div_busy;
    logic [FRACTION_BITS-1:0]   div_quot;

    logic                       mul_en;
    logic [31:0]                blend_res;

    // Handshake conditions
    assign accept   = cmd.valid && cmd.ready;
    assign full     = count_reg >= CNT_W'(MAX_SAMPLES);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || res.ready);
    assign n_m1     = AW'(count_reg - CNT_W'(1));
    assign mul_en   = state_reg == S_MUL;

    // Sample memory
    tti_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(count_reg)),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Fraction divider
    tti_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Shared blend unit
    tti_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .clk    (clk),
        .mul_en (mul_en),
        .a      (lane_val(lo_row_reg, lane_reg)),
        .b      (lane_val(hi_row_reg, lane_reg)),
        .sgn    (lane_reg != LANE_MACH),
        .f      (div_quot),
        .result (blend_res)
    );

    // Write row from the command payload
    always_comb
    begin
        ram_wdata.t      = cmd.sample_time;
        ram_wdata.pos[0] = cmd.pos_x;
        ram_wdata.pos[1] = cmd.pos_y;
        ram_wdata.pos[2] = cmd.pos_z;
        ram_wdata.vel[0] = cmd.vel_x;
        ram_wdata.vel[1] = cmd.vel_y;
        ram_wdata.vel[2] = cmd.vel_z;
        ram_wdata.mach   = cmd.mach_number;
    end

    // Binary search: set up the bracket, then narrow it by the row just read
    always_comb
    begin
        cand_lo = lo_reg;
        cand_hi = hi_reg;
        if (state_reg == S_LAST)
        begin
            cand_lo = '0;
            cand_hi = n_m1;
        end
        else if (ram_rdata.t <= qt_reg)
        begin
            cand_lo = mid_reg;
        end
        else
        begin
            cand_hi = mid_reg;
        end
        mid_sum     = {1'b0, cand_lo} + {1'b0, cand_hi};
        cand_mid    = mid_sum[AW:1];
        cand_gap    = cand_hi - cand_lo;
        search_more = cand_gap > AW'(1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == ACT_CLEAR || cmd.action == ACT_APPEND ||
                        count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FIRST;
                    end
                end
            end
            S_FIRST: state_next = (qt_reg <= ram_rdata.t) ? S_DONE : S_LAST;
            S_LAST:
            begin
                if (qt_reg >= ram_rdata.t)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = search_more ? S_SRCH : S_RDLO;
                end
            end
            S_SRCH:  state_next = search_more ? S_SRCH : S_RDLO;
            S_RDLO:  state_next = S_DIV;
            S_DIV:   state_next = div_busy ? S_DIV : S_MUL;
            S_MUL:   state_next = S_ADD;
            S_ADD:   state_next = (lane_reg == LANE_LAST) ? S_DONE : S_MUL;
            S_DONE:  state_next = out_load ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        count_next  = count_reg;
        qt_next     = qt_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        lo_row_next = lo_row_reg;
        hi_row_next = hi_row_reg;
        lane_next   = lane_reg;
        rstat_next  = rstat_reg;
        rval_next   = rval_reg;
        ram_we      = 1'b0;
        ram_raddr   = '0;
        div_start   = 1'b0;
        div_num     = qt_reg - ram_rdata.t;
        div_den     = (hi_row_reg.t > ram_rdata.t) ? hi_row_reg.t - ram_rdata.t : 32'd1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    qt_next   = cmd.query_time;
                    rval_next = '0;
                    case (cmd.action)
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            rstat_next = ST_WRITTEN;
                        end
                        ACT_APPEND:
                        begin
                            if (full)
                            begin
                                rstat_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                rstat_next = ST_WRITTEN;
                            end
                        end
                        default:
                        begin
                            rstat_next = ST_EMPTY;
                        end
                    endcase
                end
            end
            S_FIRST:
            begin
                ram_raddr = n_m1;
                if (qt_reg <= ram_rdata.t)
                begin
                    rstat_next = ST_BEFORE;
                    for (int k = 0; k < NUM_LANES; k++)
                    begin
                        rval_next[k] = lane_val(ram_rdata, 3'(k));
                    end
                end
            end
            S_LAST, S_SRCH:
            begin
                if (state_reg == S_LAST || ram_rdata.t > qt_reg)
                begin
                    hi_row_next = ram_rdata;
                end
                if (state_reg == S_LAST && qt_reg >= ram_rdata.t)
                begin
                    rstat_next = ST_AFTER;
                    for (int k = 0; k < NUM_LANES; k++)
                    begin
                        rval_next[k] = lane_val(ram_rdata, 3'(k));
                    end
                end
                lo_next   = cand_lo;
                hi_next   = cand_hi;
                mid_next  = cand_mid;
                ram_raddr = search_more ? cand_mid : cand_lo;
            end
            S_RDLO:
            begin
                lo_row_next = ram_rdata;
                div_start   = 1'b1;
                lane_next   = '0;
            end
            S_DIV, S_MUL, S_DONE:
            begin
            end
            S_ADD:
            begin
                if (lane_reg == LANE_MACH)
                begin
                    rval_next[lane_reg] = {16'h0000, blend_res[15:0]};
                    rstat_next          = ST_INTERP;
                end
                else
                begin
                    rval_next[lane_reg] = blend_res;
                end
                lane_next = lane_reg + 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        qt_reg     <= qt_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        lo_row_reg <= lo_row_next;
        hi_row_reg <= hi_row_next;
        lane_reg   <= lane_next;
        rstat_reg  <= rstat_next;
        rval_reg   <= rval_next;
        if (out_load)
        begin
            out_status_reg <= rstat_reg;
            out_val_reg    <= rval_reg;
        end
    end

    // Ports
    assign cmd.ready     = state_reg == S_IDLE;
    assign res.valid     = out_valid_reg;
    assign res.status    = out_status_reg;
    assign res.out_pos_x = $signed(out_val_reg[0]);
    assign res.out_pos_y = $signed(out_val_reg[1]);
    assign res.out_pos_z = $signed(out_val_reg[2]);
    assign res.out_vel_x = $signed(out_val_reg[3]);
    assign res.out_vel_y = $signed(out_val_reg[4]);
    assign res.out_vel_z = $signed(out_val_reg[5]);
    assign res.out_mach  = out_val_reg[LANE_MACH][15:0];

endmodule

`default_nettype wire

@@ hdl/tti_checker.sv @@
// Port-level checks for the trajectory table interpolator and their binding.
`timescale 1ns / 1ps
`default_nettype none

module tti_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cmd_valid,
    input wire logic               cmd_ready,
    input wire logic               res_valid,
    input wire logic               res_ready,
    input wire logic [2:0]         res_status,
    input wire logic signed [31:0] res_pos_x,
    input wire logic signed [31:0] res_vel_z,
    input wire logic [15:0]        res_mach
);

    import tti_pkg::*;

    // One command at a time: ready drops right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("ready stayed high after an accepted item");

    // Stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status) &&
        $stable(res_pos_x) && $stable(res_mach))
        else $error("stalled result changed");

    // Statuses without values (written, full, empty) carry zero values
    a_zero_values: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_WRITTEN || res_status == ST_FULL ||
        res_status == ST_EMPTY) |-> res_pos_x == 0 && res_vel_z == 0 && res_mach == 0)
        else $error("value fields not zero for a status without values");

    // Status code in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_status <= ST_FULL)
        else $error("status code out of range");

endmodule

bind trajectory_table_interpolator_unit tti_checker u_tti_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_status (res.status),
    .res_pos_x  (res.out_pos_x),
    .res_vel_z  (res.out_vel_z),
    .res_mach   (res.out_mach)
);

`default_nettype wire
